FILE: hw/rtl/tlvfe_pkg.sv
// ----------------------------------------------------------------------------
// TLV frame field extractor package
// Shared constants for the extractor and its checker.
// ----------------------------------------------------------------------------
package tlvfe_pkg;
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_FETCH = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [0:0] REG_WANTED_ID = 1'd0;
   localparam logic [0:0] REG_MAX_LEN   = 1'd1;

   localparam logic [7:0] MARKER_BYTE = 8'h01;
   localparam logic [7:0] TAG_SHORT   = 8'h05;
   localparam logic [7:0] TAG_FINAL   = 8'h09;

   localparam logic [7:0]  WANTED_ID_RESET = 8'h23;
   localparam logic [17:0] MAX_LEN_RESET   = 18'h20000;
endpackage

FILE: hw/rtl/tlvfe_ram.sv
// ----------------------------------------------------------------------------
// TLV extractor generic RAM
// Single-port write, single-port read, registered read data.
// ----------------------------------------------------------------------------
module tlvfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: hw/rtl/tlv_frame_field_extractor.sv
// ----------------------------------------------------------------------------
// TLV frame field extractor
// Buffers a byte stream and returns payload bytes of matching TLV records.
// ----------------------------------------------------------------------------
// Load beats (action 0) are stored one per cycle while the input is ready
// into a byte RAM of BUFFER_BYTES entries. A fetch beat (action 1) starts
// or resumes the parse and returns exactly one result beat; a clear beat
// (action 2) empties the buffer. The parser is a sequencer over the single
// RAM read port, and header bytes are read back to back. A fetch that lands
// on a payload byte goes through PAYLOAD, which issues the read, and PREAD,
// which fills the output register; no request is taken until the parser is
// back in IDLE. A fetch that has to hunt passes OUTER and OREAD for each
// byte skipped while looking for a marker, OUTER, OREAD and LEN for a frame
// header, INNER and IREAD for a record header and INNER to leave a frame at
// its end. The result is held in an output register; while it waits
// unaccepted the input is held off, so at most one result is ever pending.
// Frame lengths are checked against max_frame_len and the loaded byte count.
module tlv_frame_field_extractor
   import tlvfe_pkg::*;
#(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] action, [9:2] data_byte, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [8] has_byte,
                                    // [9] last_of_payload, [10] finished,
                                    // [11] overflow, zero fill
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [17:0] csr_wdata
);
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = AW + 1;                  // counts up to BUFFER_BYTES
   localparam int PW = (CW > 19) ? CW + 1 : 20; // positions plus frame lengths
   localparam logic [CW-1:0] CAP = CW'(BUFFER_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE, ST_OUTER, ST_OREAD, ST_LEN, ST_INNER, ST_IREAD,
      ST_PAYLOAD, ST_PREAD, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic             loading_ff, loading_in;   // parse_phase is loading
   logic             pdone_ff, pdone_in;        // parse reached the end
   logic [CW-1:0]    fill_ff, fill_in;
   logic             drop_ff, drop_in;
   logic [PW-1:0]    outer_ff, outer_in;
   logic [PW-1:0]    fend_ff, fend_in;
   logic [PW-1:0]    inner_ff, inner_in;
   logic [PW-1:0]    rem_ff, rem_in;
   logic [1:0]       step_ff, step_in;          // header byte index
   logic [7:0]       tag_ff, tag_in;
   logic [7:0]       fid_ff, fid_in;
   logic [23:0]      len_ff, len_in;
   logic [7:0]       wanted_ff;
   logic [17:0]      maxlen_ff;
   logic             ovalid_ff, ovalid_in;
   logic [11:0]      odata_ff, odata_in;

   logic [AW-1:0]    rd_addr;
   logic [7:0]       rd_data;
   logic             wr_en;
   logic [PW-1:0]    rd_pos;
   logic             accept;
   logic [1:0]       action;
   logic [7:0]       data_byte;
   logic [PW-1:0]    fill_w;

   assign action    = req_tdata[1:0];
   assign data_byte = req_tdata[9:2];
   assign req_tready = (state_ff == ST_IDLE) && !(ovalid_ff && !rsp_tready);
   assign accept    = req_tvalid && req_tready;
   assign wr_en     = accept && action == ACT_LOAD && loading_ff && fill_ff < CAP;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = {4'd0, odata_ff};
   assign fill_w    = PW'(fill_ff);

   tlvfe_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = rd_pos[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      loading_in = loading_ff;
      pdone_in   = pdone_ff;
      fill_in    = fill_ff;
      drop_in    = drop_ff;
      outer_in   = outer_ff;
      fend_in    = fend_ff;
      inner_in   = inner_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      tag_in     = tag_ff;
      fid_in     = fid_ff;
      len_in     = len_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      odata_in   = odata_ff;
      rd_pos     = inner_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_LOAD: begin
                     if (loading_ff) begin
                        if (fill_ff < CAP) fill_in = fill_ff + 1'b1;
                        else drop_in = 1'b1;
                     end
                  end
                  ACT_FETCH: begin
                     if (loading_ff) begin
                        loading_in = 1'b0;
                        outer_in   = '0;
                        state_in   = ST_OUTER;
                     end else if (pdone_ff) begin
                        state_in = ST_DONE;
                     end else if (rem_ff != '0) begin
                        state_in = ST_PAYLOAD;
                     end else begin
                        state_in = ST_INNER;
                     end
                  end
                  ACT_CLEAR: begin
                     fill_in    = '0;
                     drop_in    = 1'b0;
                     outer_in   = '0;
                     fend_in    = '0;
                     inner_in   = '0;
                     rem_in     = '0;
                     loading_in = 1'b1;
                     pdone_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_OUTER: begin
            rd_pos = outer_ff;
            step_in = 2'd0;
            if (outer_ff + PW'(4) > fill_w) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_OREAD;
               step_in  = 2'd1;
            end
         end
         ST_OREAD: begin
            // rd_data holds byte outer + step - 1; issue read of next byte
            rd_pos = outer_ff + PW'(step_ff);
            if (step_ff == 2'd1 && rd_data != MARKER_BYTE) begin
               outer_in = outer_ff + 1'b1;
               state_in = ST_OUTER;
            end else begin
               case (step_ff)
                  2'd2: len_in[7:0]   = rd_data;
                  2'd3: len_in[15:8]  = rd_data;
                  default: ;
               endcase
               if (step_ff == 2'd0) begin
                  len_in[23:16] = rd_data;
                  state_in      = ST_LEN;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_LEN: begin
            if (len_ff == '0 || len_ff > 24'(maxlen_ff)
                || outer_ff + PW'(4) + PW'(len_ff) > fill_w) begin
               outer_in = outer_ff + 1'b1;
               state_in = ST_OUTER;
            end else begin
               inner_in = outer_ff + PW'(4);
               fend_in  = outer_ff + PW'(4) + PW'(len_ff);
               state_in = ST_INNER;
            end
         end
         ST_INNER: begin
            rd_pos  = inner_ff;
            step_in = 2'd1;
            if (inner_ff + PW'(3) > fend_ff) begin
               outer_in = fend_ff;
               state_in = ST_OUTER;
            end else begin
               state_in = ST_IREAD;
            end
         end
         ST_IREAD: begin
            rd_pos = inner_ff + PW'(step_ff);
            case (step_ff)
               2'd1: begin
                  tag_in = rd_data;
                  if (rd_data != TAG_SHORT && rd_data != TAG_FINAL) begin
                     outer_in = fend_ff;
                     state_in = ST_OUTER;
                  end else begin
                     step_in = 2'd2;
                  end
               end
               2'd2: begin
                  fid_in = rd_data;
                  if (tag_ff == TAG_FINAL) begin
                     inner_in = fend_ff;
                     if (rd_data == wanted_ff && inner_ff + PW'(4) <= fend_ff) begin
                        if (inner_ff + PW'(4) == fend_ff) begin
                           ovalid_in = 1'b1;
                           odata_in  = {drop_ff, 1'b0, 1'b1, 1'b0, 8'd0};
                           state_in  = ST_IDLE;
                        end else begin
                           inner_in = inner_ff + PW'(4);
                           rem_in   = fend_ff - inner_ff - PW'(4);
                           state_in = ST_PAYLOAD;
                        end
                     end else begin
                        state_in = ST_INNER;
                     end
                  end else begin
                     step_in = 2'd3;
                  end
               end
               default: begin
                  if (inner_ff + PW'(3) + PW'(rd_data) > fend_ff) begin
                     outer_in = fend_ff;
                     state_in = ST_OUTER;
                  end else begin
                     inner_in = inner_ff + PW'(3) + PW'(rd_data);
                     state_in = ST_INNER;
                     if (fid_ff == wanted_ff) begin
                        if (rd_data == 8'd0) begin
                           ovalid_in = 1'b1;
                           odata_in  = {drop_ff, 1'b0, 1'b1, 1'b0, 8'd0};
                           state_in  = ST_IDLE;
                        end else begin
                           inner_in = inner_ff + PW'(3);
                           rem_in   = PW'(rd_data);
                           state_in = ST_PAYLOAD;
                        end
                     end
                  end
               end
            endcase
         end
         ST_PAYLOAD: begin
            rd_pos   = inner_ff;
            state_in = ST_PREAD;
         end
         ST_PREAD: begin
            // Only leave when the output register is free.
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               odata_in  = {drop_ff, 1'b0, rem_ff == PW'(1), 1'b1, rd_data};
               inner_in  = inner_ff + 1'b1;
               rem_in    = rem_ff - 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DONE: begin
            pdone_in = 1'b1;
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               odata_in  = {drop_ff, 1'b1, 1'b0, 1'b0, 8'd0};
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Empty-payload results above are only issued from IREAD; the output
      // register is free there because IDLE only accepts with it free.
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         loading_ff <= 1'b1;
         pdone_ff   <= 1'b0;
         fill_ff    <= '0;
         drop_ff    <= 1'b0;
         outer_ff   <= '0;
         fend_ff    <= '0;
         inner_ff   <= '0;
         rem_ff     <= '0;
         ovalid_ff  <= 1'b0;
         wanted_ff  <= WANTED_ID_RESET;
         maxlen_ff  <= MAX_LEN_RESET;
      end else begin
         state_ff   <= state_in;
         loading_ff <= loading_in;
         pdone_ff   <= pdone_in;
         fill_ff    <= fill_in;
         drop_ff    <= drop_in;
         outer_ff   <= outer_in;
         fend_ff    <= fend_in;
         inner_ff   <= inner_in;
         rem_ff     <= rem_in;
         ovalid_ff  <= ovalid_in;
         if (csr_we && csr_index == REG_WANTED_ID) wanted_ff <= csr_wdata[7:0];
         if (csr_we && csr_index == REG_MAX_LEN)   maxlen_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      tag_ff   <= tag_in;
      fid_ff   <= fid_in;
      len_ff   <= len_in;
      odata_ff <= odata_in;
   end
endmodule

FILE: hw/rtl/tlvfe_checker.sv
// ----------------------------------------------------------------------------
// TLV extractor port checker
// Port-level properties of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module tlvfe_checker
   import tlvfe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_finished_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[9:0] == 10'd0)
      else $error("finished result carries payload");

   a_nobyte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[7:0] == 8'd0)
      else $error("payload byte set without has_byte");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[1:0] == ACT_LOAD && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("load beat produced a result");
endmodule

bind tlv_frame_field_extractor tlvfe_checker u_tlvfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
